@@ design/twdq_pkg.sv @@
package twdq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 16;
  localparam int TIME_BITS   = 16;
  localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  typedef logic [1:0] op_t;
  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_REMOVE = 2'd1;
  localparam op_t OP_TICK   = 2'd2;
  localparam op_t OP_UNUSED = 2'd3;

  typedef logic [2:0] ev_t;
  localparam ev_t EV_INSERTED = 3'd0;
  localparam ev_t EV_REMOVED  = 3'd1;
  localparam ev_t EV_RELEASED = 3'd2;
  localparam ev_t EV_NONE_DUE = 3'd3;
  localparam ev_t EV_FULL     = 3'd4;
  localparam ev_t EV_NOTFOUND = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_SCAN,
    ST_INS_SHIFT,
    ST_REM_SCAN,
    ST_REM_SHIFT,
    ST_TICK_HEAD,
    ST_TICK_CHECK,
    ST_TICK_SHIFT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input item, reset scan index
    logic ins_step;   // insert scan: subtract delta, advance
    logic rem_step;   // remove scan: advance
    logic set_top;    // shift index := count (insert shift start)
    logic ins_move;   // copy entry [idx-1] to [idx], decrement idx
    logic ins_place;  // write new entry at pos, fix successor, count++
    logic rem_fix;    // add removed delta to successor, saturating; shift index stays at match
    logic del_move;   // copy entry [idx+1] to [idx], increment idx
    logic del_done;   // count--
    logic tick_dec;   // decrement front delta if nonzero
    logic set_zero;   // shift index := 0
    logic emit;       // output a result
    ev_t  ev;
    logic from_head;  // result id is front entry, else captured id
    logic zero_id;
    logic last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic scan_end;   // scan index reached count
    logic ins_stop;   // remainder below current delta
    logic id_match;
    logic move_end;   // shift index reached its end
    logic head_zero;  // front delta zero
    logic next_zero;  // second entry exists with zero delta
    logic more_due;   // end of release shift: another zero-delta entry in front
  } stat_t;

endpackage

@@ design/twdq_ctrl.sv @@
module twdq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  twdq_pkg::stat_t st,
  output twdq_pkg::cmd_t  cmd
);
  import twdq_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (st.op)
            OP_INSERT: state_next = ST_INS_SCAN;
            OP_REMOVE: state_next = ST_REM_SCAN;
            OP_TICK:   state_next = ST_TICK_HEAD;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_INS_SCAN: begin
        if (st.full) begin
          cmd.emit = 1'b1; cmd.ev = EV_FULL; cmd.last = 1'b1;
          state_next = ST_IDLE;
        end else if (st.scan_end || st.ins_stop) begin
          cmd.set_top = 1'b1;
          state_next = ST_INS_SHIFT;
        end else begin
          cmd.ins_step = 1'b1;
        end
      end
      ST_INS_SHIFT: begin
        if (st.move_end) begin
          cmd.ins_place = 1'b1;
          cmd.emit = 1'b1; cmd.ev = EV_INSERTED; cmd.last = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.ins_move = 1'b1;
        end
      end
      ST_REM_SCAN: begin
        if (st.scan_end) begin
          cmd.emit = 1'b1; cmd.ev = EV_NOTFOUND; cmd.last = 1'b1;
          state_next = ST_IDLE;
        end else if (st.id_match) begin
          cmd.rem_fix = 1'b1;
          state_next = ST_REM_SHIFT;
        end else begin
          cmd.rem_step = 1'b1;
        end
      end
      ST_REM_SHIFT: begin
        if (st.move_end) begin
          cmd.del_done = 1'b1;
          cmd.emit = 1'b1; cmd.ev = EV_REMOVED; cmd.last = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.del_move = 1'b1;
        end
      end
      ST_TICK_HEAD: begin
        if (st.empty) begin
          cmd.emit = 1'b1; cmd.ev = EV_NONE_DUE; cmd.zero_id = 1'b1; cmd.last = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.tick_dec = 1'b1;
          state_next = ST_TICK_CHECK;
        end
      end
      ST_TICK_CHECK: begin
        if (st.empty || !st.head_zero) begin
          cmd.emit = 1'b1; cmd.ev = EV_NONE_DUE; cmd.zero_id = 1'b1; cmd.last = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.emit = 1'b1; cmd.ev = EV_RELEASED; cmd.from_head = 1'b1;
          cmd.last = !st.next_zero;
          cmd.set_zero = 1'b1;
          state_next = ST_TICK_SHIFT;
        end
      end
      ST_TICK_SHIFT: begin
        if (st.move_end) begin
          cmd.del_done = 1'b1;
          state_next = ST_TICK_CHECK;
          if (!st.more_due) state_next = ST_IDLE;
        end else begin
          cmd.del_move = 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ design/twdq_dp.sv @@
module twdq_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [1:0]                    operation,
  input  logic [twdq_pkg::ID_BITS-1:0]   task_id,
  input  logic [twdq_pkg::TIME_BITS-1:0] wait_ticks,
  input  twdq_pkg::cmd_t                 cmd,
  output twdq_pkg::stat_t                st,
  output logic                          done,
  output logic [2:0]                    event_res,
  output logic [twdq_pkg::ID_BITS-1:0]   released_id,
  output logic                          last,
  output logic [twdq_pkg::CNT_BITS-1:0]  occupancy
);
  import twdq_pkg::*;

  logic [ID_BITS-1:0]   entry_task  [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] entry_delta [QUEUE_DEPTH];
  logic [CNT_BITS-1:0]  count;
  logic [CNT_BITS-1:0]  idx;      // scan / shift index, may reach QUEUE_DEPTH
  logic [CNT_BITS-1:0]  pos;
  logic [ID_BITS-1:0]   id_r;
  logic [TIME_BITS-1:0] rem;
  op_t                  op_r;

  logic [IDX_BITS-1:0]  ia, ib, ic;
  logic [TIME_BITS:0]   sum;
  logic [CNT_BITS-1:0]  cnt_dec;

  assign ia = idx[IDX_BITS-1:0];
  assign ib = IDX_BITS'(idx - CNT_BITS'(1));
  assign ic = IDX_BITS'(idx + CNT_BITS'(1));
  assign cnt_dec = count - CNT_BITS'(1);
  // successor delta plus the delta of the entry being removed
  assign sum = {1'b0, entry_delta[ic]} + {1'b0, entry_delta[ia]};

  always_comb begin
    st.op        = op_t'(operation);
    st.full      = (count == CNT_BITS'(QUEUE_DEPTH));
    st.empty     = (count == '0);
    st.scan_end  = (idx >= count);
    st.ins_stop  = (rem < entry_delta[ia]);
    st.id_match  = (entry_task[ia] == id_r);
    st.head_zero = (entry_delta[0] == '0);
    st.next_zero = (count > CNT_BITS'(1)) && (entry_delta[1] == '0);
    st.more_due  = (count > CNT_BITS'(1)) && (entry_delta[0] == '0);
    case (op_r)
      OP_INSERT: st.move_end = (idx <= pos);
      default:   st.move_end = (idx + CNT_BITS'(1) >= count);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cmd.ins_place) count <= count + CNT_BITS'(1);
      if (cmd.del_done)  count <= cnt_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op_t'(operation);
      id_r <= task_id;
      rem  <= wait_ticks;
      idx  <= '0;
    end
    if (cmd.ins_step) begin
      rem <= rem - entry_delta[ia];
      idx <= idx + CNT_BITS'(1);
    end
    if (cmd.rem_step) idx <= idx + CNT_BITS'(1);
    if (cmd.set_top) begin
      pos <= idx;
      idx <= count;
    end
    if (cmd.ins_move) begin
      entry_task[ia]  <= entry_task[ib];
      entry_delta[ia] <= entry_delta[ib];
      idx <= idx - CNT_BITS'(1);
    end
    if (cmd.ins_place) begin
      entry_task[pos[IDX_BITS-1:0]]  <= id_r;
      entry_delta[pos[IDX_BITS-1:0]] <= rem;
      if (pos < count)
        entry_delta[IDX_BITS'(pos + CNT_BITS'(1))] <=
          entry_delta[IDX_BITS'(pos + CNT_BITS'(1))] - rem;
    end
    if (cmd.rem_fix) begin
      // successor absorbs the removed delta, saturating
      if (idx + CNT_BITS'(1) < count)
        entry_delta[ic] <= sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
    end
    if (cmd.del_move) begin
      entry_task[ia]  <= entry_task[ic];
      entry_delta[ia] <= entry_delta[ic];
      idx <= idx + CNT_BITS'(1);
    end
    if (cmd.set_zero) idx <= '0;
    if (cmd.tick_dec && entry_delta[0] != '0)
      entry_delta[0] <= entry_delta[0] - TIME_BITS'(1);
  end

  // result register; occupancy shows the count after this result
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      event_res   <= cmd.ev;
      released_id <= cmd.zero_id ? '0 : (cmd.from_head ? entry_task[0] : id_r);
      last        <= cmd.last;
      case (cmd.ev)
        EV_INSERTED: occupancy <= count + CNT_BITS'(1);
        EV_REMOVED,
        EV_RELEASED: occupancy <= cnt_dec;
        default:     occupancy <= count;
      endcase
    end
  end

endmodule

@@ design/timed_wait_delta_queue.sv @@
// Delta-list timer queue of up to QUEUE_DEPTH waiting task ids. Pulse
// start with operation, task_id and wait_ticks while busy is low; results
// come back one per strobe on done, each valid for a single cycle and not
// stallable, so the receiver must take every strobe. All entries move one
// per cycle through the shared shift index of the datapath; each result
// strobe is registered and rises in the cycle after the command producing it.
// Insert scans to its slot and then shifts the tail up, or reports full when
// the list is full. Remove scans to the match and then shifts the tail down,
// or reports not found when the scan ends without a match. A tick on an
// empty list reports nothing due; otherwise it decrements a nonzero front
// delta and reports nothing due if the front is still not zero, else gives,
// per released entry, a result and a shift pass.
// No clearing pass: entries above the count are never read.
module timed_wait_delta_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [15:0] task_id,
  input  logic [15:0] wait_ticks,
  output logic        done,
  output logic [2:0]  event_res,
  output logic [15:0] released_id,
  output logic        last,
  output logic [4:0]  occupancy
);
  import twdq_pkg::*;

  cmd_t  cmd;
  stat_t st;
  logic  busy_c;

  twdq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy_c), .st(st), .cmd(cmd)
  );

  twdq_dp u_dp (
    .clk(clk), .rst(rst), .operation(operation), .task_id(task_id),
    .wait_ticks(wait_ticks), .cmd(cmd), .st(st), .done(done),
    .event_res(event_res), .released_id(released_id), .last(last),
    .occupancy(occupancy)
  );

  assign busy = busy_c;

endmodule

@@ design/twdq_check.sv @@
module twdq_check (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] operation,
  input logic       done,
  input logic [2:0] event_res,
  input logic       last,
  input logic [4:0] occupancy
);
  import twdq_pkg::*;

  a_occ: assert property (@(posedge clk) disable iff (rst)
    done |-> occupancy <= 5'(QUEUE_DEPTH)) else $error("occupancy range");
  a_single: assert property (@(posedge clk) disable iff (rst)
    done && event_res != EV_RELEASED |-> last) else $error("last missing");
  a_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy && operation != OP_UNUSED |=> busy) else $error("no work");
  a_res: assert property (@(posedge clk) disable iff (rst)
    done |-> event_res <= EV_NOTFOUND) else $error("bad event");

endmodule

bind timed_wait_delta_queue twdq_check u_check (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
  .done(done), .event_res(event_res), .last(last), .occupancy(occupancy)
);
